### src/assert_macros.svh
// Assertion macros shared by the heap queue RTL.
// Each macro expands to one labeled concurrent assertion on a clock and a reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// When ante holds, cons holds in the same cycle.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// When ante holds, cons holds in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/bmhq_pkg.sv
// Package for the binary min-heap queue: command and status codes, result type.
// Used by the sequencer and the top level; depends on nothing.
`timescale 1ns / 1ps

package bmhq_pkg;

   localparam int KeyWidth = 32;

   localparam logic CMD_INSERT  = 1'b0;
   localparam logic CMD_EXTRACT = 1'b1;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic [7:0]          count;
      logic [KeyWidth-1:0] key;
      logic [1:0]          status;
   } rsp_type;

endpackage

### src/bmhq_store.sv
// Heap storage: one write port and two read ports, read data registered.
// Used by the top level; depends on nothing.
`timescale 1ns / 1ps

module bmhq_store #(
   parameter int DEPTH = 128,
   parameter int AW    = 7,
   parameter int DW    = 32
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic [AW-1:0] rd_addr_a,
   input  logic [AW-1:0] rd_addr_b,
   output logic [DW-1:0] rd_data_a,
   output logic [DW-1:0] rd_data_b
);

   logic [DW-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

### src/bmhq_seq.sv
// Sequencer for the heap queue: takes one command, walks the sift loop over
// the heap memory and presents one result. Depends on bmhq_pkg.
`timescale 1ns / 1ps

module bmhq_seq #(
   parameter int CAPACITY = 128,
   parameter int AW       = 7,
   parameter int CW       = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        cmd_valid,
   input  logic                        cmd_op,
   input  logic [31:0]                 cmd_key,
   output logic                        cmd_ready,
   output logic                        res_valid,
   input  logic                        res_ready,
   output bmhq_pkg::rsp_type           res,
   output logic                        mem_we,
   output logic [AW-1:0]               mem_waddr,
   output logic [31:0]                 mem_wdata,
   output logic [AW-1:0]               mem_ra,
   output logic [AW-1:0]               mem_rb,
   input  logic [31:0]                 mem_qa,
   input  logic [31:0]                 mem_qb
);
   import bmhq_pkg::*;

   localparam int KW = CW + 1;

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_INS_CHK  = 3'd1;
   localparam logic [2:0] S_INS_CMP  = 3'd2;
   localparam logic [2:0] S_EXT_LOAD = 3'd3;
   localparam logic [2:0] S_DN_CHK   = 3'd4;
   localparam logic [2:0] S_DN_CMP   = 3'd5;
   localparam logic [2:0] S_FIN      = 3'd6;

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] pos_ff, pos_in;
   logic [KW-1:0] kid_ff, kid_in;
   logic [31:0]   key_ff, key_in;
   logic [31:0]   top_ff, top_in;
   logic [1:0]    status_ff, status_in;

   logic [AW-1:0] up_idx;
   logic [KW-1:0] kid_next;
   logic [KW-1:0] count_ext;
   logic          right_ok;
   logic          pick_right;
   logic [31:0]   child_key;
   logic [AW-1:0] child_idx;

   assign up_idx     = AW'((pos_ff - AW'(1)) >> 1);
   assign kid_next   = kid_ff + KW'(1);
   assign count_ext  = KW'(count_ff);
   assign right_ok   = kid_next < count_ext;
   assign pick_right = right_ok && ($signed(mem_qb) < $signed(mem_qa));
   assign child_key  = pick_right ? mem_qb : mem_qa;
   assign child_idx  = pick_right ? kid_next[AW-1:0] : kid_ff[AW-1:0];

   assign cmd_ready  = (state_ff == S_IDLE);
   assign res_valid  = (state_ff == S_FIN);
   assign res.status = status_ff;
   assign res.key    = top_ff;
   assign res.count  = 8'({8'd0, count_ff});

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      pos_in    = pos_ff;
      kid_in    = kid_ff;
      key_in    = key_ff;
      top_in    = top_ff;
      status_in = status_ff;
      mem_we    = 1'b0;
      mem_waddr = pos_ff;
      mem_wdata = key_ff;
      mem_ra    = kid_ff[AW-1:0];
      mem_rb    = kid_next[AW-1:0];
      case (state_ff)
         S_IDLE: begin
            mem_ra = '0;
            mem_rb = AW'(count_ff - CW'(1));
            if (cmd_valid) begin
               top_in    = '0;
               status_in = ST_OK;
               case (cmd_op)
                  CMD_INSERT: begin
                     if (count_ff == CW'(CAPACITY)) begin
                        status_in = ST_FULL;
                        state_in  = S_FIN;
                     end else begin
                        pos_in   = count_ff[AW-1:0];
                        key_in   = cmd_key;
                        count_in = count_ff + CW'(1);
                        state_in = S_INS_CHK;
                     end
                  end
                  CMD_EXTRACT: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                        state_in  = S_FIN;
                     end else begin
                        count_in = count_ff - CW'(1);
                        state_in = S_EXT_LOAD;
                     end
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_INS_CHK: begin
            mem_ra = up_idx;
            if (pos_ff == '0) begin
               mem_we   = 1'b1;
               state_in = S_FIN;
            end else begin
               state_in = S_INS_CMP;
            end
         end
         S_INS_CMP: begin
            mem_we = 1'b1;
            if ($signed(key_ff) < $signed(mem_qa)) begin
               mem_wdata = mem_qa;
               pos_in    = up_idx;
               state_in  = S_INS_CHK;
            end else begin
               state_in = S_FIN;
            end
         end
         S_EXT_LOAD: begin
            top_in   = mem_qa;
            key_in   = mem_qb;
            pos_in   = '0;
            kid_in   = KW'(1);
            state_in = S_DN_CHK;
         end
         S_DN_CHK: begin
            if (kid_ff >= count_ext) begin
               mem_we   = 1'b1;
               state_in = S_FIN;
            end else begin
               state_in = S_DN_CMP;
            end
         end
         S_DN_CMP: begin
            mem_we = 1'b1;
            if ($signed(key_ff) < $signed(child_key)) begin
               state_in = S_FIN;
            end else begin
               mem_wdata = child_key;
               pos_in    = child_idx;
               kid_in    = KW'({child_idx, 1'b1});
               state_in  = S_DN_CHK;
            end
         end
         S_FIN: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      pos_ff    <= pos_in;
      kid_ff    <= kid_in;
      key_ff    <= key_in;
      top_ff    <= top_in;
      status_ff <= status_in;
   end

endmodule

### src/binary_min_heap_queue.sv
// Channel  Direction  Payload (lowest bits first)
// req      in         tdata: key_in[31:0]; tuser: cmd
// rsp      out        tdata: key_out[31:0], count_out[39:32]; tuser: status
//
// One command at a time. Each level of a sift passes a check state and a compare state. A
// sift that a compare stops finishes from that compare state; one that reaches the root
// (insert) or runs out of children (extract) finishes from the check state.
// Reset clears the count and the sequencer; the heap memory needs no clearing.
// A result waits in the output register while the next command is taken; that
// command's result then holds the sequencer until the register frees.
// Top level of the heap queue; depends on bmhq_pkg, bmhq_store, bmhq_seq and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module binary_min_heap_queue #(
   parameter int CAPACITY = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // key_in[31:0]
   input  logic [0:0]  req_tuser,   // cmd[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // key_out[31:0], count_out[39:32]
   output logic [1:0]  rsp_tuser    // status[1:0]
);
   import bmhq_pkg::*;

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [7:0] FULL_COUNT = 8'(CAPACITY);

   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [31:0]   mem_wdata;
   logic [AW-1:0] mem_ra;
   logic [AW-1:0] mem_rb;
   logic [31:0]   mem_qa;
   logic [31:0]   mem_qb;

   logic          res_valid;
   logic          res_ready;
   rsp_type       res;

   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   logic          req_fire;
   logic          rsp_full;
   logic          rsp_empty;
   logic          full_count_ok;
   logic          empty_clean;

   bmhq_store #(
      .DEPTH(CAPACITY),
      .AW(AW),
      .DW(KeyWidth)
   ) u_store (
      .clock(clock),
      .wr_en(mem_we),
      .wr_addr(mem_waddr),
      .wr_data(mem_wdata),
      .rd_addr_a(mem_ra),
      .rd_addr_b(mem_rb),
      .rd_data_a(mem_qa),
      .rd_data_b(mem_qb)
   );

   bmhq_seq #(
      .CAPACITY(CAPACITY),
      .AW(AW),
      .CW(CW)
   ) u_seq (
      .clock(clock),
      .reset(reset),
      .cmd_valid(req_tvalid),
      .cmd_op(req_tuser[0]),
      .cmd_key(req_tdata),
      .cmd_ready(req_tready),
      .res_valid(res_valid),
      .res_ready(res_ready),
      .res(res),
      .mem_we(mem_we),
      .mem_waddr(mem_waddr),
      .mem_wdata(mem_wdata),
      .mem_ra(mem_ra),
      .mem_rb(mem_rb),
      .mem_qa(mem_qa),
      .mem_qb(mem_qb)
   );

   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_ready) begin
         rsp_valid_in = res_valid;
         rsp_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ff.count, rsp_ff.key};
   assign rsp_tuser  = rsp_ff.status;

   assign req_fire      = req_tvalid && req_tready;
   assign rsp_full      = rsp_valid_ff && (rsp_ff.status == ST_FULL);
   assign rsp_empty     = rsp_valid_ff && (rsp_ff.status == ST_EMPTY);
   assign full_count_ok = (rsp_ff.count == FULL_COUNT);
   assign empty_clean   = (rsp_ff.count == 8'd0) && (rsp_ff.key == '0);

   `ASSERT_NEXT(a_one_at_a_time, clock, reset, req_fire, !req_tready, "command taken while busy")
   `ASSERT_SAME(a_full_count, clock, reset, rsp_full, full_count_ok, "full status below capacity")
   `ASSERT_SAME(a_empty_result, clock, reset, rsp_empty, empty_clean, "empty status with a key")

endmodule

### verif/tb_binary_min_heap_queue.sv
// Self-checking testbench for binary_min_heap_queue: a directed table of commands,
// then random insert/extract phases checked against an in-bench heap of its own.
// Depends on bmhq_pkg and the binary_min_heap_queue RTL.
`timescale 1ns / 1ps

module tb_binary_min_heap_queue;
   import bmhq_pkg::*;

   localparam int Capacity = 128;
   localparam int IdlePct = 14;
   localparam int QuietLimit = 4000;
   localparam int HoldCycles = 300;
   localparam int DrainCycles = 40;

   typedef struct {
      logic        cmd;
      logic [31:0] key;
      bit          typed;
      logic [1:0]  status;
      logic [31:0] key_out;
      logic [7:0]  count;
   } op_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // key_in[31:0]
   logic [0:0]  req_tuser;   // cmd[0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;   // key_out[31:0], count_out[39:32]
   logic [1:0]  rsp_tuser;   // status[1:0]

   logic signed [31:0] heap_mem [0:Capacity-1];
   int                 heap_count;
   rsp_type            op_outcomes[$];
   op_row_type         directed_ops[$];
   op_row_type         offer;
   int                 errors;
   int                 rsp_seen;
   int                 items_sent;
   int                 quiet_cycles;
   bit                 send_calm;

   binary_min_heap_queue #(
      .CAPACITY(Capacity)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   function automatic rsp_type heap_apply(logic cmd, logic signed [31:0] key);
      rsp_type            res;
      int                 pos;
      int                 up;
      int                 kid;
      int                 n;
      bit                 stop;
      logic signed [31:0] moved;
      res.status = ST_OK;
      res.key = '0;
      stop = 1'b0;
      if (cmd == CMD_INSERT) begin
         if (heap_count >= Capacity) begin
            res.status = ST_FULL;
         end else begin
            pos = heap_count;
            while (pos > 0 && !stop) begin
               up = (pos - 1) / 2;
               if (!(key < heap_mem[up])) begin
                  stop = 1'b1;
               end else begin
                  heap_mem[pos] = heap_mem[up];
                  pos = up;
               end
            end
            heap_mem[pos] = key;
            heap_count++;
         end
      end else begin
         if (heap_count == 0) begin
            res.status = ST_EMPTY;
         end else begin
            res.key = heap_mem[0];
            n = heap_count - 1;
            moved = heap_mem[n];
            pos = 0;
            kid = 1;
            heap_count = n;
            while (kid < n && !stop) begin
               if (kid + 1 < n && heap_mem[kid+1] < heap_mem[kid]) kid++;
               if (moved < heap_mem[kid]) begin
                  stop = 1'b1;
               end else begin
                  heap_mem[pos] = heap_mem[kid];
                  pos = kid;
                  kid = 2 * pos + 1;
               end
            end
            heap_mem[pos] = moved;
         end
      end
      res.count = heap_count[7:0];
      return res;
   endfunction

   task automatic add_row(logic cmd, logic [31:0] key, bit typed,
                          logic [1:0] status, logic [31:0] key_out, logic [7:0] count);
      op_row_type row;
      row.cmd = cmd;
      row.key = key;
      row.typed = typed;
      row.status = status;
      row.key_out = key_out;
      row.count = count;
      directed_ops.push_back(row);
   endtask

   task automatic add_op(logic cmd, logic [31:0] key);
      add_row(cmd, key, 1'b0, ST_OK, '0, '0);
   endtask

   // Called right after a falling edge; returns at the falling edge after the transfer.
   task automatic send_op(op_row_type row);
      while (!send_calm && $urandom_range(99) < IdlePct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= row.key;
      req_tuser <= row.cmd;
      offer <= row;
      do @(posedge clock); while (!req_tready);
      items_sent++;
      @(negedge clock);
   endtask

   function automatic logic [31:0] rand_key();
      logic [31:0] k;
      case ($urandom_range(5))
         3, 4: k = $urandom_range(16) - 8;
         5: begin
            case ($urandom_range(3))
               0: k = 32'h7fff_ffff;
               1: k = 32'h8000_0000;
               2: k = 32'h0000_0000;
               default: k = 32'hffff_ffff;
            endcase
         end
         default: k = $urandom;
      endcase
      return k;
   endfunction

   // Result check first, then the prediction for a newly accepted command.
   always @(posedge clock) begin
      rsp_type exp;
      rsp_type got;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_seen++;
            got.status = rsp_tuser;
            got.key = rsp_tdata[31:0];
            got.count = rsp_tdata[39:32];
            if (op_outcomes.size() == 0) begin
               $display("%0t: unexpected result status %0d key %h count %0d",
                        $time, got.status, got.key, got.count);
               errors++;
            end else begin
               exp = op_outcomes.pop_front();
               if (got.status !== exp.status) begin
                  $display("%0t: status expected %0d actual %0d", $time, exp.status, got.status);
                  errors++;
               end
               if (got.key !== exp.key) begin
                  $display("%0t: key_out expected %h actual %h", $time, exp.key, got.key);
                  errors++;
               end
               if (got.count !== exp.count) begin
                  $display("%0t: count_out expected %0d actual %0d",
                           $time, exp.count, got.count);
                  errors++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            exp = heap_apply(offer.cmd, offer.key);
            if (offer.typed) begin
               exp.status = offer.status;
               exp.key = offer.key_out;
               exp.count = offer.count;
            end
            op_outcomes.push_back(exp);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
         $display("%0t: no transfer for %0d cycles", $time, QuietLimit);
         $display("tb_binary_min_heap_queue: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Receiver: random stalls, one calm stretch and one long hold-off.
   initial begin
      int  hold_left;
      bit  hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (!hold_done && rsp_seen >= 250) begin
            hold_done = 1'b1;
            hold_left = HoldCycles;
            rsp_tready <= 1'b0;
         end else if (rsp_seen >= 350 && rsp_seen < 450) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= IdlePct);
         end
      end
   end

   initial begin
      op_row_type row;
      int         phase_len [4];
      int         insert_pct [4];
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = CMD_INSERT;
      offer = '{default: '0};
      errors = 0;
      rsp_seen = 0;
      items_sent = 0;
      quiet_cycles = 0;
      send_calm = 1'b0;
      heap_count = 0;
      for (int i = 0; i < Capacity; i++) heap_mem[i] = '0;

      add_row(CMD_EXTRACT, 32'h0000_0000, 1'b1, ST_EMPTY, '0, 8'd0);
      add_row(CMD_INSERT,  32'h7fff_ffff, 1'b1, ST_OK, '0, 8'd1);
      add_row(CMD_INSERT,  32'h8000_0000, 1'b1, ST_OK, '0, 8'd2);
      add_row(CMD_EXTRACT, 32'hffff_ffff, 1'b1, ST_OK, 32'h8000_0000, 8'd1);
      add_row(CMD_EXTRACT, 32'hdead_beef, 1'b1, ST_OK, 32'h7fff_ffff, 8'd0);
      add_row(CMD_EXTRACT, 32'hffff_ffff, 1'b1, ST_EMPTY, '0, 8'd0);
      add_row(CMD_INSERT,  32'h0000_0000, 1'b1, ST_OK, '0, 8'd1);
      // Duplicate keys exercise both tie rules of the sifts.
      add_op(CMD_INSERT, 32'd5);
      add_op(CMD_INSERT, 32'd5);
      add_op(CMD_INSERT, 32'hffff_ffff);
      add_op(CMD_INSERT, 32'd5);
      add_op(CMD_INSERT, 32'd3);
      add_op(CMD_INSERT, 32'd5);
      add_op(CMD_INSERT, 32'd0);
      add_op(CMD_INSERT, 32'hffff_ffff);
      for (int i = 0; i < 9; i++) add_op(CMD_EXTRACT, $urandom);
      add_row(CMD_EXTRACT, 32'h5555_aaaa, 1'b1, ST_EMPTY, '0, 8'd0);

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_ops[i]) send_op(directed_ops[i]);

      // Mixed, fill past full, drain past empty, mixed again.
      phase_len = '{120, 170, 170, 70};
      insert_pct = '{50, 90, 10, 50};
      row.typed = 1'b0;
      row.status = ST_OK;
      row.key_out = '0;
      row.count = '0;
      for (int p = 0; p < 4; p++) begin
         for (int i = 0; i < phase_len[p]; i++) begin
            send_calm = (items_sent >= 130 && items_sent < 230);
            row.cmd = ($urandom_range(99) < insert_pct[p]) ? CMD_INSERT : CMD_EXTRACT;
            row.key = rand_key();
            send_op(row);
         end
      end
      req_tvalid <= 1'b0;

      while (op_outcomes.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (errors == 0) begin
         $display("tb_binary_min_heap_queue: PASS");
      end else begin
         $display("tb_binary_min_heap_queue: FAIL");
      end
      $finish;
   end

endmodule
